/* rtl/core/simon64_pkg.sv */
// ----------------------------------------------------------------------------
// simon64_pkg
// shared types, constants and the round function for the simon 64/128 block
// ----------------------------------------------------------------------------
package simon64_pkg;

   localparam int unsigned WORD_W        = 32;
   localparam int unsigned KEY_DEPTH     = 44;
   localparam int unsigned KEY_ADDR_W    = $clog2(KEY_DEPTH);
   localparam int unsigned ROUNDS_DEFAULT = 44;
   localparam int unsigned QUEUE_DEPTH   = 2;

   typedef enum logic {
      OP_KEY_WRITE = 1'b0,
      OP_ENCRYPT   = 1'b1
   } op_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ROUND,
      ST_DONE
   } back_state_type;

   // one command as it travels from the front to the back
   typedef struct packed {
      op_type                  op;
      logic [KEY_ADDR_W-1:0]   key_index;
      logic [WORD_W-1:0]       key_word;
      logic [WORD_W-1:0]       left;
      logic [WORD_W-1:0]       right;
   } cmd_type;

   // (x rotl 1) & (x rotl 8) ^ (x rotl 2)
   function automatic logic [WORD_W-1:0] simon_f(input logic [WORD_W-1:0] x);
      logic [WORD_W-1:0] r1;
      logic [WORD_W-1:0] r2;
      logic [WORD_W-1:0] r8;
      r1 = {x[WORD_W-2:0], x[WORD_W-1]};
      r2 = {x[WORD_W-3:0], x[WORD_W-1:WORD_W-2]};
      r8 = {x[WORD_W-9:0], x[WORD_W-1:WORD_W-8]};
      return (r1 & r8) ^ r2;
   endfunction

endpackage

/* rtl/core/simon64_block_encrypt.sv */
// ----------------------------------------------------------------------------
// simon64_block_encrypt
// simon 64/128 encryption over a loaded table of round keys
// ----------------------------------------------------------------------------
// flow: the back takes a new command only while idle; an encrypt runs on the
//   single round unit and the one-read-port key memory and is held until its
//   response transfers; a key write is stored as it is taken from the queue
// reset: clears the queue and the round sequencer; the key table is not
//   cleared and holds nothing defined until written
// ----------------------------------------------------------------------------
module simon64_block_encrypt #(
   parameter int unsigned ROUNDS = simon64_pkg::ROUNDS_DEFAULT
) (
   input  logic                                  clock,
   input  logic                                  reset,
   // request channel
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic                                  req_op,
   input  logic [simon64_pkg::KEY_ADDR_W-1:0]    req_key_index,
   input  logic [simon64_pkg::WORD_W-1:0]        req_key_word,
   input  logic [simon64_pkg::WORD_W-1:0]        req_plain_left,
   input  logic [simon64_pkg::WORD_W-1:0]        req_plain_right,
   // response channel
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic [simon64_pkg::WORD_W-1:0]        rsp_cipher_left,
   output logic [simon64_pkg::WORD_W-1:0]        rsp_cipher_right
);

   // front to queue
   logic                 push_valid;
   logic                 push_ready;
   simon64_pkg::cmd_type push_cmd;

   // queue to back
   logic                 pop_valid;
   logic                 pop_ready;
   simon64_pkg::cmd_type pop_cmd;

   // front: decodes each request transfer, drops key writes past the table
   simon64_front u_front (
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_op          (req_op),
      .req_key_index   (req_key_index),
      .req_key_word    (req_key_word),
      .req_plain_left  (req_plain_left),
      .req_plain_right (req_plain_right),
      .push_valid      (push_valid),
      .push_ready      (push_ready),
      .push_cmd        (push_cmd)
   );

   // key writes and encrypts share one queue so their order is kept
   simon64_cmd_fifo u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_cmd   (push_cmd),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_cmd    (pop_cmd)
   );

   // back: key table and the round loop, result held until transfer
   simon64_back #(
      .ROUNDS (ROUNDS)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .pop_valid        (pop_valid),
      .pop_ready        (pop_ready),
      .pop_cmd          (pop_cmd),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_cipher_left  (rsp_cipher_left),
      .rsp_cipher_right (rsp_cipher_right)
   );

endmodule

/* rtl/core/simon64_front.sv */
// ----------------------------------------------------------------------------
// simon64_front
// takes request transfers, drops key writes beyond the table, queues the rest
// ----------------------------------------------------------------------------
module simon64_front (
   input  logic                                      req_valid,
   output logic                                      req_ready,
   input  logic                                      req_op,
   input  logic [simon64_pkg::KEY_ADDR_W-1:0]        req_key_index,
   input  logic [simon64_pkg::WORD_W-1:0]            req_key_word,
   input  logic [simon64_pkg::WORD_W-1:0]            req_plain_left,
   input  logic [simon64_pkg::WORD_W-1:0]            req_plain_right,
   output logic                                      push_valid,
   input  logic                                      push_ready,
   output simon64_pkg::cmd_type                      push_cmd
);

   logic index_ok;
   logic is_encrypt;

   assign is_encrypt = (simon64_pkg::op_type'(req_op) == simon64_pkg::OP_ENCRYPT);
   assign index_ok   = (req_key_index < simon64_pkg::KEY_ADDR_W'(simon64_pkg::KEY_DEPTH));

   // out-of-range key writes are taken and dropped here
   assign req_ready  = push_ready;
   assign push_valid = req_valid && (is_encrypt || index_ok);

   always_comb begin
      push_cmd.op        = simon64_pkg::op_type'(req_op);
      push_cmd.key_index = req_key_index;
      push_cmd.key_word  = req_key_word;
      push_cmd.left      = req_plain_left;
      push_cmd.right     = req_plain_right;
   end

endmodule

/* rtl/core/simon64_cmd_fifo.sv */
// ----------------------------------------------------------------------------
// simon64_cmd_fifo
// short command queue between front and back
// ----------------------------------------------------------------------------
module simon64_cmd_fifo (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push_valid,
   output logic                 push_ready,
   input  simon64_pkg::cmd_type push_cmd,
   output logic                 pop_valid,
   input  logic                 pop_ready,
   output simon64_pkg::cmd_type pop_cmd
);

   localparam int unsigned PTR_W = $clog2(simon64_pkg::QUEUE_DEPTH);
   localparam int unsigned CNT_W = $clog2(simon64_pkg::QUEUE_DEPTH + 1);

   simon64_pkg::cmd_type slot_ff [simon64_pkg::QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff,  count_in;
   logic             do_push;
   logic             do_pop;

   assign push_ready = (count_ff != CNT_W'(simon64_pkg::QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_cmd    = slot_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(simon64_pkg::QUEUE_DEPTH - 1)) ? '0
                     : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(simon64_pkg::QUEUE_DEPTH - 1)) ? '0
                     : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

/* rtl/core/simon64_back.sv */
// ----------------------------------------------------------------------------
// simon64_back
// round-key store and the iterative round datapath, one round a cycle
// ----------------------------------------------------------------------------
module simon64_back #(
   parameter int unsigned ROUNDS = simon64_pkg::ROUNDS_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               pop_valid,
   output logic                               pop_ready,
   input  simon64_pkg::cmd_type               pop_cmd,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [simon64_pkg::WORD_W-1:0]     rsp_cipher_left,
   output logic [simon64_pkg::WORD_W-1:0]     rsp_cipher_right
);

   localparam int unsigned CNT_W = $clog2(ROUNDS);
   localparam int unsigned AW    = simon64_pkg::KEY_ADDR_W;
   localparam int unsigned W     = simon64_pkg::WORD_W;

   simon64_pkg::back_state_type state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [W-1:0]     x_ff, x_in;
   logic [W-1:0]     y_ff, y_in;
   logic [W-1:0]     key_rd_ff;
   logic [W-1:0]     key_mem [simon64_pkg::KEY_DEPTH];
   logic [AW-1:0]    rd_addr;
   logic             rd_en;
   logic             wr_en;
   logic             last_round;
   logic             take;

   assign last_round = (cnt_ff == CNT_W'(ROUNDS - 1));
   assign take       = pop_valid && pop_ready;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         simon64_pkg::ST_IDLE: begin
            if (pop_valid && pop_cmd.op == simon64_pkg::OP_ENCRYPT) begin
               state_in = simon64_pkg::ST_ROUND;
            end
         end
         simon64_pkg::ST_ROUND: begin
            if (last_round) begin
               state_in = simon64_pkg::ST_DONE;
            end
         end
         simon64_pkg::ST_DONE: begin
            if (rsp_ready) begin
               state_in = simon64_pkg::ST_IDLE;
            end
         end
         default: state_in = simon64_pkg::ST_IDLE;
      endcase
   end

   // outputs and datapath controls
   always_comb begin
      pop_ready = 1'b0;
      rsp_valid = 1'b0;
      rd_en     = 1'b0;
      wr_en     = 1'b0;
      rd_addr   = '0;
      cnt_in    = cnt_ff;
      x_in      = x_ff;
      y_in      = y_ff;
      case (state_ff)
         simon64_pkg::ST_IDLE: begin
            pop_ready = 1'b1;
            if (pop_valid && pop_cmd.op == simon64_pkg::OP_ENCRYPT) begin
               rd_en  = 1'b1;
               cnt_in = '0;
               x_in   = pop_cmd.left;
               y_in   = pop_cmd.right;
            end else if (pop_valid) begin
               wr_en = 1'b1;
            end
         end
         simon64_pkg::ST_ROUND: begin
            // prefetch the key for the following round
            rd_en   = !last_round;
            rd_addr = AW'(cnt_ff) + AW'(1);
            cnt_in  = cnt_ff + CNT_W'(1);
            x_in    = simon64_pkg::simon_f(x_ff) ^ y_ff ^ key_rd_ff;
            y_in    = x_ff;
         end
         simon64_pkg::ST_DONE: begin
            rsp_valid = 1'b1;
         end
         default: ;
      endcase
   end

   assign rsp_cipher_left  = x_ff;
   assign rsp_cipher_right = y_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= simon64_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      x_ff   <= x_in;
      y_ff   <= y_in;
   end

   // round-key memory, registered read
   always_ff @(posedge clock) begin
      if (wr_en && take) begin
         key_mem[pop_cmd.key_index] <= pop_cmd.key_word;
      end
      if (rd_en) begin
         key_rd_ff <= key_mem[rd_addr];
      end
   end

endmodule

/* dv/tb_simon64_block_encrypt.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_simon64_block_encrypt
// self-checking bench for the simon 64/128 block encrypter: loads the round
// key table, encrypts directed and random blocks and compares every response
// against an in-bench cipher model, with random sender gaps and receiver stalls
// ----------------------------------------------------------------------------
module tb_simon64_block_encrypt;

   localparam int unsigned ROUND_COUNT  = simon64_pkg::ROUNDS_DEFAULT;
   localparam int unsigned CLOCK_PERIOD = 12;
   localparam int unsigned HOLD_CYCLES  = 400;
   localparam int unsigned DRAIN_CYCLES = ROUND_COUNT + 20;
   localparam int unsigned RANDOM_ITEMS = 500;
   localparam int unsigned TIMEOUT_NS   = 6_000_000;

   typedef struct packed {
      logic [simon64_pkg::WORD_W-1:0] left;
      logic [simon64_pkg::WORD_W-1:0] right;
   } cipher_block_type;

   // receiver behaviour between long hold-offs
   typedef enum logic [1:0] {
      SINK_OPEN,
      SINK_RANDOM,
      SINK_SPARSE,
      SINK_PATTERN
   } sink_mode_type;

   logic                               clock;
   logic                               reset;
   logic                               req_valid;
   logic                               req_ready;
   logic                               req_op;
   logic [simon64_pkg::KEY_ADDR_W-1:0] req_key_index;
   logic [simon64_pkg::WORD_W-1:0]     req_key_word;
   logic [simon64_pkg::WORD_W-1:0]     req_plain_left;
   logic [simon64_pkg::WORD_W-1:0]     req_plain_right;
   logic                               rsp_valid;
   logic                               rsp_ready;
   logic [simon64_pkg::WORD_W-1:0]     rsp_cipher_left;
   logic [simon64_pkg::WORD_W-1:0]     rsp_cipher_right;

   // bench copy of the round key table and the ciphertexts still owed
   logic [simon64_pkg::WORD_W-1:0]     round_key_mem [simon64_pkg::KEY_DEPTH];
   cipher_block_type                   pending_ciphers [$];
   int unsigned                        mismatch_count;

   // sender pacing and receiver hold-off control
   bit                    sender_gaps;
   int unsigned           burst_left;
   bit                    hold_request;
   int unsigned           hold_left;

   simon64_block_encrypt #(
      .ROUNDS(ROUND_COUNT)
   ) dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_op          (req_op),
      .req_key_index   (req_key_index),
      .req_key_word    (req_key_word),
      .req_plain_left  (req_plain_left),
      .req_plain_right (req_plain_right),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_cipher_left (rsp_cipher_left),
      .rsp_cipher_right(rsp_cipher_right)
   );

   initial begin
      clock = 1'b0;
      forever #(CLOCK_PERIOD / 2) clock = ~clock;
   end

   // hard stop in case the block hangs
   initial begin
      #(TIMEOUT_NS);
      $display("RESULT: ERROR");
      $finish;
   end

   // --------------------------------------------------------------------------
   // cipher model
   // --------------------------------------------------------------------------

   function automatic logic [simon64_pkg::WORD_W-1:0] rotate_left(
         input logic [simon64_pkg::WORD_W-1:0] v,
         input int unsigned                    n);
      return (v << n) | (v >> (simon64_pkg::WORD_W - n));
   endfunction

   // full feistel pass over the bench key table, one key per round
   function automatic cipher_block_type encrypt_block(
         input logic [simon64_pkg::WORD_W-1:0] left,
         input logic [simon64_pkg::WORD_W-1:0] right);
      logic [simon64_pkg::WORD_W-1:0] x;
      logic [simon64_pkg::WORD_W-1:0] y;
      logic [simon64_pkg::WORD_W-1:0] mixed;
      cipher_block_type               blk;
      x = left;
      y = right;
      for (int unsigned r = 0; r < ROUND_COUNT; r++) begin
         mixed = (rotate_left(x, 1) & rotate_left(x, 8)) ^ rotate_left(x, 2);
         mixed = mixed ^ y ^ round_key_mem[r];
         y     = x;
         x     = mixed;
      end
      blk.left  = x;
      blk.right = y;
      return blk;
   endfunction

   // update the model for one accepted request transfer
   function automatic void apply_command(
         input simon64_pkg::op_type              op,
         input logic [simon64_pkg::KEY_ADDR_W-1:0] idx,
         input logic [simon64_pkg::WORD_W-1:0]   word,
         input logic [simon64_pkg::WORD_W-1:0]   left,
         input logic [simon64_pkg::WORD_W-1:0]   right);
      if (op == simon64_pkg::OP_KEY_WRITE) begin
         // writes past the end of the table are dropped by the block
         if (idx < simon64_pkg::KEY_DEPTH) round_key_mem[idx] = word;
      end else begin
         pending_ciphers.push_back(encrypt_block(left, right));
      end
   endfunction

   // --------------------------------------------------------------------------
   // request side
   // --------------------------------------------------------------------------

   // one request transfer; valid is left high so back-to-back items never dip
   task automatic send_command(
         input simon64_pkg::op_type              op,
         input logic [simon64_pkg::KEY_ADDR_W-1:0] idx,
         input logic [simon64_pkg::WORD_W-1:0]   word,
         input logic [simon64_pkg::WORD_W-1:0]   left,
         input logic [simon64_pkg::WORD_W-1:0]   right);
      int unsigned gap;
      if (sender_gaps && burst_left == 0) begin
         // mostly short gaps, now and then one long enough to shift the round phase
         gap = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 6);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
         burst_left = $urandom_range(1, 12);
      end
      if (burst_left != 0) burst_left--;
      req_valid       <= 1'b1;
      req_op          <= op;
      req_key_index   <= idx;
      req_key_word    <= word;
      req_plain_left  <= left;
      req_plain_right <= right;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      apply_command(op, idx, word, left, right);
   endtask

   // key write with junk in the plaintext fields
   task automatic write_key(input logic [simon64_pkg::KEY_ADDR_W-1:0] idx,
                            input logic [simon64_pkg::WORD_W-1:0]     word);
      send_command(simon64_pkg::OP_KEY_WRITE, idx, word, $urandom, $urandom);
   endtask

   // encrypt with junk in the key fields
   task automatic encrypt(input logic [simon64_pkg::WORD_W-1:0] left,
                          input logic [simon64_pkg::WORD_W-1:0] right);
      send_command(simon64_pkg::OP_ENCRYPT,
                   simon64_pkg::KEY_ADDR_W'($urandom_range(0, 63)), $urandom,
                   left, right);
   endtask

   // --------------------------------------------------------------------------
   // response side
   // --------------------------------------------------------------------------

   task automatic report_mismatch(input string what,
                                  input logic [simon64_pkg::WORD_W-1:0] got,
                                  input logic [simon64_pkg::WORD_W-1:0] want);
      $display("mismatch at %0t: %s got %h want %h", $realtime, what, got, want);
      mismatch_count++;
   endtask

   // receiver: own stall pattern, plus a long hold-off on request
   initial begin
      sink_mode_type     mode;
      int unsigned       mode_left;
      logic [15:0]       stall_pattern;
      int unsigned       pattern_pos;
      rsp_ready     <= 1'b0;
      mode          = SINK_OPEN;
      mode_left     = 0;
      stall_pattern = 16'b1011_0010_1110_0001;
      pattern_pos   = 0;
      forever begin
         @(posedge clock);
         if (hold_left != 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else if (hold_request) begin
            hold_request = 1'b0;
            hold_left    = HOLD_CYCLES;
            rsp_ready    <= 1'b0;
         end else begin
            if (mode_left == 0) begin
               mode      = sink_mode_type'($urandom_range(0, 3));
               mode_left = $urandom_range(20, 200);
            end
            mode_left--;
            case (mode)
               SINK_OPEN: begin
                  rsp_ready <= 1'b1;
               end
               SINK_RANDOM: begin
                  rsp_ready <= 1'($urandom_range(0, 1));
               end
               SINK_SPARSE: begin
                  rsp_ready <= ($urandom_range(0, 4) == 0);
               end
               default: begin
                  rsp_ready   <= stall_pattern[pattern_pos];
                  pattern_pos = (pattern_pos + 1) % 16;
               end
            endcase
         end
      end
   end

   // compare each response transfer with the oldest owed ciphertext
   always @(posedge clock) begin
      cipher_block_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_ciphers.size() == 0) begin
            report_mismatch("response with nothing owed, left", rsp_cipher_left, 'x);
         end else begin
            want = pending_ciphers.pop_front();
            if (rsp_cipher_left !== want.left)
               report_mismatch("cipher_left", rsp_cipher_left, want.left);
            if (rsp_cipher_right !== want.right)
               report_mismatch("cipher_right", rsp_cipher_right, want.right);
         end
      end
   end

   // --------------------------------------------------------------------------
   // tests
   // --------------------------------------------------------------------------

   // every table entry written before any encrypt reads it
   task automatic test_key_table_load();
      logic [simon64_pkg::WORD_W-1:0] word;
      for (int unsigned k = 0; k < simon64_pkg::KEY_DEPTH; k++) begin
         case (k)
            0:       word = '0;
            1:       word = '1;
            2:       word = 32'h8000_0000;
            3:       word = 32'h0000_0001;
            default: word = $urandom;
         endcase
         write_key(simon64_pkg::KEY_ADDR_W'(k), word);
      end
   endtask

   // plaintext corners, including single top and bottom bits
   task automatic test_block_extremes();
      logic [simon64_pkg::WORD_W-1:0] lefts  [9];
      logic [simon64_pkg::WORD_W-1:0] rights [9];
      lefts  = '{32'h0, 32'hFFFF_FFFF, 32'h8000_0000, 32'h0, 32'h1, 32'h0,
                 32'hFFFF_FFFF, 32'h0, 32'hAAAA_AAAA};
      rights = '{32'h0, 32'hFFFF_FFFF, 32'h0, 32'h8000_0000, 32'h0, 32'h1,
                 32'h0, 32'hFFFF_FFFF, 32'h5555_5555};
      for (int unsigned n = 0; n < 9; n++) encrypt(lefts[n], rights[n]);
   endtask

   // unused fields at all-ones or all-zeros must not leak into the operation
   task automatic test_ignored_fields();
      send_command(simon64_pkg::OP_KEY_WRITE, '0, 32'hFFFF_FFFF, '1, '1);
      send_command(simon64_pkg::OP_KEY_WRITE,
                   simon64_pkg::KEY_ADDR_W'(simon64_pkg::KEY_DEPTH - 1), 32'h0, '1, '1);
      send_command(simon64_pkg::OP_ENCRYPT, '1, '1, 32'h0123_4567, 32'h89AB_CDEF);
      send_command(simon64_pkg::OP_ENCRYPT, '0, '0, 32'hFEDC_BA98, 32'h7654_3210);
   endtask

   // writes past the table end are dropped, table unchanged afterwards
   task automatic test_out_of_range_index();
      write_key(simon64_pkg::KEY_ADDR_W'(simon64_pkg::KEY_DEPTH), 32'hFFFF_FFFF);
      write_key('1, 32'hFFFF_FFFF);
      encrypt($urandom, $urandom);
   endtask

   // receiver holds off long enough for the block to fill and stall the sender
   task automatic test_backpressure();
      hold_request = 1'b1;
      for (int unsigned n = 0; n < 10; n++) encrypt($urandom, $urandom);
      while (hold_request || hold_left != 0) @(posedge clock);
   endtask

   // mostly encrypts, with key rewrites and dropped writes mixed in
   task automatic test_random_traffic();
      int unsigned done_items;
      int unsigned pick;
      done_items  = 0;
      sender_gaps = 1'b1;
      burst_left  = 0;
      while (done_items < RANDOM_ITEMS) begin
         // a stretch with no sender gaps in the middle of the run
         sender_gaps = !(done_items >= 250 && done_items < 350);
         pick = $urandom_range(0, 99);
         if (pick < 75) begin
            encrypt($urandom, $urandom);
            done_items++;
         end else if (pick < 95) begin
            write_key(simon64_pkg::KEY_ADDR_W'($urandom_range(0, simon64_pkg::KEY_DEPTH - 1)),
                      $urandom);
            done_items++;
         end else begin
            // dropped write, does not count toward the item total
            write_key(simon64_pkg::KEY_ADDR_W'($urandom_range(simon64_pkg::KEY_DEPTH, 63)),
                      $urandom);
         end
      end
      sender_gaps = 1'b0;
   endtask

   // --------------------------------------------------------------------------
   // main sequence
   // --------------------------------------------------------------------------

   initial begin
      reset           <= 1'b1;
      req_valid       <= 1'b0;
      req_op          <= simon64_pkg::OP_KEY_WRITE;
      req_key_index   <= '0;
      req_key_word    <= '0;
      req_plain_left  <= '0;
      req_plain_right <= '0;
      mismatch_count  = 0;
      sender_gaps     = 1'b0;
      burst_left      = 0;
      hold_request    = 1'b0;
      hold_left       = 0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      test_key_table_load();
      test_block_extremes();
      test_ignored_fields();
      test_out_of_range_index();
      test_backpressure();
      test_random_traffic();

      req_valid <= 1'b0;
      // let every owed ciphertext come back, then watch for strays
      while (pending_ciphers.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

/* filelist.f */
rtl/core/simon64_pkg.sv
rtl/core/simon64_front.sv
rtl/core/simon64_cmd_fifo.sv
rtl/core/simon64_back.sv
rtl/core/simon64_block_encrypt.sv
dv/tb_simon64_block_encrypt.sv
